FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);

`endif

FILE: src/ibhc_pkg.sv
// types, codes and constants of the sound-bank header checker
package ibhc_pkg;

	localparam int WORD_W   = 16;
	localparam int CNT_W    = 9;
	localparam int REASON_W = 4;
	localparam int POS_W    = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 16;
	localparam int NUM_W    = 15;

	// verdict reason codes
	typedef enum logic [REASON_W-1:0] {
		RSN_OK       = 4'd0,
		RSN_ODD      = 4'd1,
		RSN_LARGE    = 4'd2,
		RSN_ORDER    = 4'd3,
		RSN_UNIT     = 4'd4,
		RSN_GAP      = 4'd5,
		RSN_FEW      = 4'd6,
		RSN_MANY     = 4'd7,
		RSN_SHORT    = 4'd8,
		RSN_INST_GAP = 4'd9
	} reason_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MIX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEC_VEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LFO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PTR_LIM  = 3'd5;

	// configuration reset values
	localparam logic [7:0]        RST_MAX_MIX  = 8'd20;
	localparam logic [7:0]        RST_MAX_VEL  = 8'd20;
	localparam logic [7:0]        RST_SPEC_VEL = 8'd100;
	localparam logic [7:0]        RST_MAX_ENV  = 8'd30;
	localparam logic [7:0]        RST_MAX_LFO  = 8'd20;
	localparam logic [WORD_W-1:0] RST_PTR_LIM  = 16'h1000;

	// header word positions
	localparam logic [POS_W-1:0] POS_VEL  = 9'd1;
	localparam logic [POS_W-1:0] POS_ENV  = 9'd2;
	localparam logic [POS_W-1:0] POS_LFO  = 9'd3;
	localparam logic [POS_W-1:0] POS_INST = 9'd4;
	localparam logic [POS_W-1:0] POS_WALK = 9'd5;

	localparam logic [WORD_W-1:0] MIN_HDR_BYTES = 16'd8;
	localparam logic [WORD_W-1:0] MIN_MIX_PTR   = 16'd10;
	localparam logic [WORD_W-1:0] MIN_INST_PTR  = 16'd4;
	localparam logic [4:0]        INST_GAP_MOD  = 5'd4;

	// modular inverses for exact divisibility tests on 15-bit values
	localparam logic [NUM_W-1:0] INV9 = 15'd3641;
	localparam logic [NUM_W-1:0] LIM9 = 15'd3640;
	localparam logic [NUM_W-1:0] INV5 = 15'd19661;
	localparam logic [NUM_W-1:0] LIM5 = 15'd6553;

	// flags gathered while the four table pointers arrive
	typedef struct packed {
		logic unit_mix;
		logic unit_vel;
		logic unit_env;
		logic gap_mix;
		logic gap_vel;
		logic gap_env;
		logic short_hdr;
		logic odd;
		logic ptr_big;
		logic order;
		logic few;
		logic many;
		logic short_tab;
		logic [NUM_W-1:0] num;
	} hdr_chk_t;

	// x divisible by 9
	function automatic logic div9(input logic [NUM_W-1:0] x);
		logic [2*NUM_W-1:0] p;
		p = x * INV9;
		return p[NUM_W-1:0] <= LIM9;
	endfunction

	// x divisible by 5
	function automatic logic div5(input logic [NUM_W-1:0] x);
		logic [2*NUM_W-1:0] p;
		p = x * INV5;
		return p[NUM_W-1:0] <= LIM5;
	endfunction

	// table count times table size
	function automatic logic [WORD_W-1:0] mul18(input logic [7:0] n);
		return WORD_W'({n, 4'b0000}) + WORD_W'({n, 1'b0});
	endfunction

	function automatic logic [WORD_W-1:0] mul10(input logic [7:0] n);
		return WORD_W'({n, 3'b000}) + WORD_W'({n, 1'b0});
	endfunction

	function automatic logic [WORD_W-1:0] mul4(input logic [7:0] n);
		return WORD_W'({n, 2'b00});
	endfunction

endpackage

FILE: src/instrument_bank_header_check.sv
// sound-bank header checker: input register, check logic, verdict register
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata header_word, bytes_available; tuser start_of_candidate
// m_*      out  m_tvalid/m_tready  tdata accepted, instrument_count, reject_reason
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// one word per cycle sustained while the verdict is not stalled; the verdict register is
// loaded from the check logic fed by the input register. Checks span words 1 to 4, one
// constant-divisibility multiply per word on 1 to 3, so no stage holds more than one.
// Reset clears control and loads the register defaults; no clearing pass.
// A stalled verdict holds the check stage; the input register still takes one word.
module instrument_bank_header_check #(
	parameter int MAX_INSTRUMENTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [15:0] header_word, [31:16] bytes_available
	input  logic [2*ibhc_pkg::WORD_W-1:0]    s_tdata,
	// [0] start_of_candidate
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] accepted, [9:1] instrument_count, [13:10] reject_reason, [15:14] zero
	output logic [15:0]                      m_tdata,
	input  logic                             cfg_we,
	input  logic [ibhc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ibhc_pkg::CFG_W-1:0]       cfg_data
);
	import ibhc_pkg::*;

	// configuration
	logic [7:0]        max_mix_q, max_vel_q, spec_vel_q, max_env_q, max_lfo_q;
	logic [WORD_W-1:0] ptr_lim_q;

	// input register
	logic              valid_s1;
	logic              start_s1;
	logic [WORD_W-1:0] word_s1;
	logic [WORD_W-1:0] bytes_s1;

	// candidate state
	logic              idle_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] mix_q, vel_q, env_q, lfo_q, prev_q, rem_q;
	logic [CNT_W-1:0]  expected_q;
	hdr_chk_t          chk_q;

	// verdict register
	logic              out_valid_q;
	logic              out_acc_q;
	logic [CNT_W-1:0]  out_cnt_q;
	reason_t           out_rsn_q;

	// check stage results
	logic              out_free, proc;
	logic              emit;
	reason_t           rsn;
	logic [CNT_W-1:0]  cnt;
	logic              idle_d;
	logic [POS_W-1:0]  pos_d;
	logic [CNT_W-1:0]  expected_d;
	logic [WORD_W-1:0] prev_d;
	hdr_chk_t          chk_d;
	logic [WORD_W-1:0] gap, d3, dp;
	logic [NUM_W-1:0]  num;

	assign out_free = !out_valid_q || m_tready;
	assign proc     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_rsn_q, out_cnt_q, out_acc_q};

	// per-word checks and next candidate state
	always_comb begin
		emit       = 1'b0;
		rsn        = RSN_OK;
		cnt        = '0;
		idle_d     = idle_q;
		pos_d      = pos_q;
		expected_d = expected_q;
		prev_d     = prev_q;
		chk_d      = chk_q;
		gap        = word_s1 - mix_q;
		d3         = word_s1 - lfo_q;
		dp         = word_s1 - prev_q;
		num        = NUM_W'((mix_q - MIN_HDR_BYTES) >> 1);
		if (start_s1) begin
			idle_d     = 1'b0;
			pos_d      = POS_VEL;
			prev_d     = '0;
			expected_d = '0;
		end else if (!idle_q) begin
			case (pos_q)
				POS_VEL: begin
					gap            = word_s1 - mix_q;
					chk_d.unit_mix = gap[0] || !div9(gap[WORD_W-1:1]);
					chk_d.gap_mix  = gap > mul18(max_mix_q);
					pos_d          = POS_ENV;
				end
				POS_ENV: begin
					gap            = word_s1 - vel_q;
					chk_d.unit_vel = gap[0] || !div5(gap[WORD_W-1:1]);
					chk_d.gap_vel  = (gap > mul10(max_vel_q)) && (gap != mul10(spec_vel_q));
					pos_d          = POS_LFO;
				end
				POS_LFO: begin
					gap             = word_s1 - env_q;
					chk_d.unit_env  = gap[0] || !div5(gap[WORD_W-1:1]);
					chk_d.gap_env   = gap > mul10(max_env_q);
					chk_d.short_hdr = rem_q < MIN_HDR_BYTES;
					chk_d.odd       = mix_q[0] || vel_q[0] || env_q[0] || word_s1[0];
					chk_d.ptr_big   = (mix_q >= ptr_lim_q) || (vel_q >= ptr_lim_q)
						|| (env_q >= ptr_lim_q);
					chk_d.order     = !((mix_q < vel_q) && (vel_q < env_q) && (env_q < word_s1));
					chk_d.few       = mix_q < MIN_MIX_PTR;
					chk_d.many      = num > NUM_W'(MAX_INSTRUMENTS);
					// table of 8 + 2*count bytes equals the mixer pointer here
					chk_d.short_tab = mix_q > rem_q;
					chk_d.num       = num;
					pos_d           = POS_INST;
				end
				POS_INST: begin
					emit = 1'b1;
					if (chk_q.short_hdr) begin
						rsn = RSN_SHORT;
					end else if (chk_q.odd) begin
						rsn = RSN_ODD;
					end else if (chk_q.ptr_big) begin
						rsn = RSN_LARGE;
					end else if (chk_q.order) begin
						rsn = RSN_ORDER;
					end else if (chk_q.unit_mix || chk_q.unit_vel || chk_q.unit_env
						|| (d3[1:0] != 2'b00)) begin
						rsn = RSN_UNIT;
					end else if (chk_q.gap_mix || chk_q.gap_vel || chk_q.gap_env
						|| (word_s1 < lfo_q) || (d3 > mul4(max_lfo_q))) begin
						rsn = RSN_GAP;
					end else if (chk_q.few) begin
						rsn = RSN_FEW;
					end else if (chk_q.many) begin
						rsn = RSN_MANY;
					end else if (chk_q.short_tab) begin
						rsn = RSN_SHORT;
					end else if (word_s1 < MIN_INST_PTR) begin
						rsn = RSN_INST_GAP;
					end else begin
						rsn        = RSN_OK;
						expected_d = chk_q.num[CNT_W-1:0];
						prev_d     = word_s1;
						if (chk_q.num[CNT_W-1:0] <= CNT_W'(1)) begin
							cnt = chk_q.num[CNT_W-1:0];
						end else begin
							emit  = 1'b0;
							pos_d = POS_WALK;
						end
					end
					if (emit) begin
						idle_d = 1'b1;
					end
				end
				default: begin
					// instrument pointer walk
					if ((word_s1 <= prev_q) || (dp[4:0] != INST_GAP_MOD)) begin
						emit   = 1'b1;
						rsn    = RSN_INST_GAP;
						idle_d = 1'b1;
					end else begin
						prev_d = word_s1;
						if (POS_W'(pos_q - POS_LFO) >= expected_q) begin
							emit   = 1'b1;
							rsn    = RSN_OK;
							cnt    = expected_q;
							idle_d = 1'b1;
						end else begin
							pos_d = pos_q + POS_W'(1);
						end
					end
				end
			endcase
		end
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			idle_q      <= 1'b1;
			pos_q       <= '0;
			expected_q  <= '0;
			max_mix_q   <= RST_MAX_MIX;
			max_vel_q   <= RST_MAX_VEL;
			spec_vel_q  <= RST_SPEC_VEL;
			max_env_q   <= RST_MAX_ENV;
			max_lfo_q   <= RST_MAX_LFO;
			ptr_lim_q   <= RST_PTR_LIM;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_q <= proc && emit;
			end
			if (proc) begin
				idle_q     <= idle_d;
				pos_q      <= pos_d;
				expected_q <= expected_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_MIX:  max_mix_q  <= cfg_data[7:0];
					CFG_MAX_VEL:  max_vel_q  <= cfg_data[7:0];
					CFG_SPEC_VEL: spec_vel_q <= cfg_data[7:0];
					CFG_MAX_ENV:  max_env_q  <= cfg_data[7:0];
					CFG_MAX_LFO:  max_lfo_q  <= cfg_data[7:0];
					CFG_PTR_LIM:  ptr_lim_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1  <= s_tdata[WORD_W-1:0];
			bytes_s1 <= s_tdata[2*WORD_W-1:WORD_W];
			start_s1 <= s_tuser;
		end
		if (proc) begin
			prev_q <= prev_d;
			chk_q  <= chk_d;
			if (start_s1) begin
				mix_q <= word_s1;
				rem_q <= bytes_s1;
			end else if (!idle_q) begin
				if (pos_q == POS_VEL) begin
					vel_q <= word_s1;
				end
				if (pos_q == POS_ENV) begin
					env_q <= word_s1;
				end
				if (pos_q == POS_LFO) begin
					lfo_q <= word_s1;
				end
			end
		end
		if (proc && emit) begin
			out_acc_q <= (rsn == RSN_OK);
			out_cnt_q <= cnt;
			out_rsn_q <= rsn;
		end
	end

endmodule

FILE: src/ibhc_checker.sv
// port-level checks of the header checker and their binding
`include "assert_macros.svh"

module ibhc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import ibhc_pkg::*;

	// a stalled verdict word stays put
	`ASSERT_ALWAYS(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "verdict word changed while stalled")

	// accepted exactly when the reason is ok
	`ASSERT_ALWAYS(a_acc_reason, clk, arst_n, m_tvalid |-> (m_tdata[0] == (m_tdata[13:10] == RSN_OK)), "accept flag disagrees with reason")

	// a rejected candidate reports no instruments
	`ASSERT_NEVER(a_rej_count, clk, arst_n, m_tvalid && !m_tdata[0] && (m_tdata[9:1] != 9'd0), "rejected verdict with nonzero count")

	// an accepted candidate has at least one instrument
	`ASSERT_NEVER(a_acc_count, clk, arst_n, m_tvalid && m_tdata[0] && (m_tdata[9:1] == 9'd0), "accepted verdict with zero count")

	// reason code within the defined range and padding zero
	`ASSERT_NEVER(a_reason_range, clk, arst_n, m_tvalid && ((m_tdata[13:10] > RSN_INST_GAP) || (m_tdata[15:14] != 2'b00)), "undefined reason code")

endmodule

bind instrument_bank_header_check ibhc_checker u_ibhc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/tb_instrument_bank_header_check.sv
// testbench for the sound-bank header checker: directed and random candidates, scoreboard
`timescale 1ns / 100ps

module tb_instrument_bank_header_check;
	import ibhc_pkg::*;

	// table sizes in bytes and instrument pointer rules
	localparam int unsigned MIX_BYTES   = 18;
	localparam int unsigned VEL_BYTES   = 10;
	localparam int unsigned ENV_BYTES   = 10;
	localparam int unsigned LFO_BYTES   = 4;
	localparam int unsigned INST_STRIDE = 32;
	localparam int unsigned MAX_INST    = 256;

	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned PHASE_WORDS  = 170;
	localparam int unsigned PHASES       = 4;
	localparam int unsigned SEND_IDLE [PHASES] = '{0, 73, 0, 13};
	localparam int unsigned RECV_STALL[PHASES] = '{0, 0, 73, 13};

	// ways of breaking a well-formed header
	typedef enum int unsigned {
		SPOIL_RANDOM,
		SPOIL_BIT,
		SPOIL_NUDGE,
		SPOIL_BYTES,
		SPOIL_CUT,
		SPOIL_SWAP
	} spoil_t;

	typedef struct packed {
		logic             accepted;
		logic [CNT_W-1:0] count;
		reason_t          reason;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// register copies
	int unsigned lim_mix  = RST_MAX_MIX;
	int unsigned lim_vel  = RST_MAX_VEL;
	int unsigned spec_vel = RST_SPEC_VEL;
	int unsigned lim_env  = RST_MAX_ENV;
	int unsigned lim_lfo  = RST_MAX_LFO;
	int unsigned ptr_lim  = RST_PTR_LIM;

	// checker state mirror
	logic [POS_W-1:0] walk_pos = '0;
	int unsigned p_mix, p_vel, p_env, p_lfo, prev_inst, inst_due, bytes_left;
	bit          verdict_out = 1'b1;

	verdict_t    verdicts_due[$];
	logic [15:0] hdr_words[$];
	logic [15:0] hdr_bytes;
	int unsigned words_fed = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	instrument_bank_header_check DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		// [15:0] header_word, [31:16] bytes_available
		.s_tdata   (s_tdata),
		// [0] start_of_candidate
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// [0] accepted, [9:1] instrument_count, [13:10] reject_reason
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run time guard
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// verdict scoreboard, sampled mid-cycle ahead of the accepting edge
	always @(negedge clk) begin : verdict_check
		verdict_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				due = verdicts_due.pop_front();
				if (m_tdata[0] !== due.accepted) begin
					$display("%0t: accepted expected %0d got %0d", $time,
						due.accepted, m_tdata[0]);
					errors++;
				end
				if (m_tdata[9:1] !== due.count) begin
					$display("%0t: instrument_count expected %0d got %0d", $time,
						due.count, m_tdata[9:1]);
					errors++;
				end
				if (m_tdata[13:10] !== due.reason) begin
					$display("%0t: reject_reason expected %0d got %0d", $time,
						due.reason, m_tdata[13:10]);
					errors++;
				end
			end
		end
	end

	function automatic void post_verdict(input reason_t rsn, input int unsigned num);
		verdict_t v;
		v.accepted = (rsn == RSN_OK);
		v.count    = (rsn == RSN_OK) ? CNT_W'(num) : '0;
		v.reason   = rsn;
		verdicts_due = {verdicts_due, v};
		verdict_out = 1'b1;
	endfunction

	// header checks made when the first instrument pointer arrives
	function automatic reason_t screen_header(input int unsigned first,
		output int unsigned num_out);
		int unsigned gap_mix, gap_vel, gap_env, gap_lfo, num;
		num_out = 0;
		if (bytes_left < MIN_HDR_BYTES) return RSN_SHORT;
		if (((p_mix | p_vel | p_env | p_lfo) & 1) != 0) return RSN_ODD;
		if (p_mix >= ptr_lim || p_vel >= ptr_lim || p_env >= ptr_lim) return RSN_LARGE;
		if (!(p_mix < p_vel && p_vel < p_env && p_env < p_lfo)) return RSN_ORDER;
		gap_mix = p_vel - p_mix;
		gap_vel = p_env - p_vel;
		gap_env = p_lfo - p_env;
		gap_lfo = first - p_lfo;
		if (gap_mix % MIX_BYTES != 0 || gap_vel % VEL_BYTES != 0 ||
			gap_env % ENV_BYTES != 0 || (gap_lfo & (LFO_BYTES - 1)) != 0) return RSN_UNIT;
		if (gap_mix > lim_mix * MIX_BYTES) return RSN_GAP;
		// an exact special velocity count passes despite its limit
		if (gap_vel > lim_vel * VEL_BYTES && gap_vel != spec_vel * VEL_BYTES) return RSN_GAP;
		if (gap_env > lim_env * ENV_BYTES) return RSN_GAP;
		if (first < p_lfo || gap_lfo > lim_lfo * LFO_BYTES) return RSN_GAP;
		if (p_mix < MIN_MIX_PTR) return RSN_FEW;
		num = (p_mix - MIN_HDR_BYTES) / 2;
		if (num > MAX_INST) return RSN_MANY;
		if (MIN_HDR_BYTES + num * 2 > bytes_left) return RSN_SHORT;
		if (first < MIN_INST_PTR) return RSN_INST_GAP;
		num_out = num;
		return RSN_OK;
	endfunction

	// advance the mirror by one word; returns 1 when the word is ignored
	function automatic bit predict_word(input logic [15:0] word, input logic start,
		input logic [15:0] bytes);
		reason_t     rsn;
		int unsigned num;
		if (start) begin
			verdict_out = 1'b0;
			bytes_left  = bytes;
			p_mix       = word;
			prev_inst   = 0;
			inst_due    = 0;
			walk_pos    = POS_VEL;
			return 1'b0;
		end
		if (verdict_out) return 1'b1;
		case (walk_pos)
			POS_VEL: begin
				p_vel    = word;
				walk_pos = POS_ENV;
			end
			POS_ENV: begin
				p_env    = word;
				walk_pos = POS_LFO;
			end
			POS_LFO: begin
				p_lfo    = word;
				walk_pos = POS_INST;
			end
			POS_INST: begin
				rsn = screen_header(word, num);
				if (rsn != RSN_OK) begin
					post_verdict(rsn, 0);
				end else begin
					inst_due  = num;
					prev_inst = word;
					if (num <= 1) post_verdict(RSN_OK, num);
					else walk_pos = POS_WALK;
				end
			end
			default: begin
				// pointer walk: rising, step mod 32 fixed
				if (word <= prev_inst ||
					((32'(word) - prev_inst) & (INST_STRIDE - 1)) != INST_GAP_MOD) begin
					post_verdict(RSN_INST_GAP, 0);
				end else begin
					prev_inst = word;
					if (walk_pos - POS_INST + 1 >= inst_due) post_verdict(RSN_OK, inst_due);
					else walk_pos = walk_pos + 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	// one word over the input channel, with random idle cycles ahead of it
	task automatic send_word(input logic [15:0] word, input logic start,
		input logic [15:0] bytes);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {bytes, word};
		s_tuser  <= start;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		if (!predict_word(word, start, bytes)) words_fed++;
	endtask

	task automatic send_candidate();
		for (int i = 0; i < hdr_words.size(); i++)
			send_word(hdr_words[i], i == 0, (i == 0) ? hdr_bytes : 16'($urandom));
	endtask

	task automatic play(input logic [15:0] bytes);
		hdr_bytes = bytes;
		send_candidate();
	endtask

	// input quiet until every verdict is in and the pipeline is empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_MAX_MIX:  lim_mix  = val[7:0];
			CFG_MAX_VEL:  lim_vel  = val[7:0];
			CFG_SPEC_VEL: spec_vel = val[7:0];
			CFG_MAX_ENV:  lim_env  = val[7:0];
			CFG_MAX_LFO:  lim_lfo  = val[7:0];
			CFG_PTR_LIM:  ptr_lim  = val;
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [7:0] mix, input logic [7:0] vel,
		input logic [7:0] spec, input logic [7:0] env, input logic [7:0] lfo,
		input logic [15:0] plim);
		// zero words close an open candidate so no check spans a register write
		while (!verdict_out) send_word(16'd0, 1'b0, 16'd0);
		wait_drained();
		write_reg(CFG_MAX_MIX, CFG_W'(mix));
		write_reg(CFG_MAX_VEL, CFG_W'(vel));
		write_reg(CFG_SPEC_VEL, CFG_W'(spec));
		write_reg(CFG_MAX_ENV, CFG_W'(env));
		write_reg(CFG_MAX_LFO, CFG_W'(lfo));
		write_reg(CFG_PTR_LIM, plim);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned at_least_one(input int unsigned x);
		return (x == 0) ? 1 : x;
	endfunction

	// well-formed header for the current registers, n_inst pointers
	task automatic build_header(input int unsigned n_inst, input bit use_special);
		int unsigned m, v, e, l, p;
		m = MIN_HDR_BYTES + 2 * n_inst;
		v = m + MIX_BYTES * $urandom_range(at_least_one(lim_mix), 1);
		if (use_special && spec_vel != 0) e = v + VEL_BYTES * spec_vel;
		else e = v + VEL_BYTES * $urandom_range(at_least_one(lim_vel), 1);
		l = e + ENV_BYTES * $urandom_range(at_least_one(lim_env), 1);
		p = l + LFO_BYTES * $urandom_range(lim_lfo, 0);
		hdr_words = {m[15:0], v[15:0], e[15:0], l[15:0]};
		for (int k = 0; k < at_least_one(n_inst); k++) begin
			hdr_words = {hdr_words, p[15:0]};
			p = p + LFO_BYTES + INST_STRIDE * $urandom_range(3, 0);
		end
		hdr_bytes = 16'(MIN_HDR_BYTES + 2 * n_inst + $urandom_range(64, 0));
	endtask

	// one defect in an otherwise good candidate
	task automatic spoil_header();
		int unsigned idx, cut;
		logic [15:0] held;
		idx = $urandom_range((hdr_words.size() > 10) ? 9 : hdr_words.size() - 1, 0);
		case (spoil_t'($urandom_range(SPOIL_SWAP, SPOIL_RANDOM)))
			SPOIL_RANDOM: hdr_words[idx] = 16'($urandom);
			SPOIL_BIT:    hdr_words[idx] = hdr_words[idx] ^ (16'd1 << $urandom_range(15, 0));
			SPOIL_NUDGE:  hdr_words[idx] = hdr_words[idx] + 16'($urandom_range(4, 0)) - 16'd2;
			SPOIL_BYTES:  hdr_bytes = 16'($urandom_range(hdr_words.size() * 2 + 4, 0));
			SPOIL_CUT: begin
				// cut short: the next start abandons it
				cut = $urandom_range(hdr_words.size() - 1, 1);
				while (hdr_words.size() > cut) void'(hdr_words.pop_back());
			end
			default: begin
				if (idx + 1 < hdr_words.size()) begin
					held               = hdr_words[idx];
					hdr_words[idx]     = hdr_words[idx + 1];
					hdr_words[idx + 1] = held;
				end
			end
		endcase
	endtask

	// mostly short tables, a few near and past the instrument limit
	function automatic int unsigned pick_count();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 1) return $urandom_range(MAX_INST + 2, MAX_INST - 40);
		if (r < 8) return $urandom_range(1, 0);
		return $urandom_range(12, 2);
	endfunction

	// every header reject reason under the reset register values
	task automatic test_header_rejects();
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd54};
		play(16'd7);
		hdr_words = {16'd12, 16'd31, 16'd40, 16'd50, 16'd54};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd4096, 16'd4106, 16'd4110};
		play(16'd64);
		hdr_words = {16'd30, 16'd12, 16'd40, 16'd50, 16'd54};
		play(16'd64);
		hdr_words = {16'd12, 16'd32, 16'd42, 16'd52, 16'd56};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd56};
		play(16'd64);
		// one table past each limit
		hdr_words = {16'd12, 16'd390, 16'd400, 16'd410, 16'd414};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd240, 16'd250, 16'd254};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd350, 16'd354};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd134};
		play(16'd64);
		// first instrument pointer below the lfo pointer
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd46};
		play(16'd64);
		// velocity gap equal to the special count
		hdr_words = {16'd12, 16'd30, 16'd1030, 16'd1040, 16'd1044, 16'd1080};
		play(16'd64);
		hdr_words = {16'd8, 16'd26, 16'd36, 16'd46, 16'd50};
		play(16'd64);
		hdr_words = {16'd522, 16'd540, 16'd550, 16'd560, 16'd564};
		play(16'hFFFF);
		// pointer table longer than the file
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd54};
		play(16'd11);
	endtask

	// instrument pointer walk, restart and ignored words
	task automatic test_table_walk();
		hdr_words = {16'd10, 16'd28, 16'd38, 16'd48, 16'd52};
		play(16'd10);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd54, 16'd90};
		play(16'd12);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd54, 16'd62};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd54, 16'd54};
		play(16'd64);
		// zero words past the end of the file
		hdr_words = {16'd14, 16'd32, 16'd42, 16'd52, 16'd56, 16'd92, 16'd0};
		play(16'd14);
		// restart in the middle of a header
		hdr_words = {16'd12, 16'd30, 16'd40};
		play(16'd64);
		hdr_words = {16'd12, 16'd30, 16'd40, 16'd50, 16'd54, 16'd90};
		play(16'd64);
		send_word(16'hFFFF, 1'b0, 16'hFFFF);
		send_word(16'h0000, 1'b0, 16'h0000);
	endtask

	task automatic test_register_extremes();
		load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		repeat (3) begin
			build_header($urandom_range(6, 2), 1'b0);
			send_candidate();
		end
		load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
		repeat (6) begin
			build_header($urandom_range(6, 1), $urandom_range(1, 0));
			send_candidate();
		end
		// only the special velocity count can pass
		load_config(8'd1, 8'd0, 8'd5, 8'd1, 8'd0, 16'd700);
		repeat (4) begin
			build_header($urandom_range(4, 1), $urandom_range(1, 0));
			send_candidate();
		end
	endtask

	task automatic test_largest_table();
		load_config(RST_MAX_MIX, RST_MAX_VEL, RST_SPEC_VEL, RST_MAX_ENV, RST_MAX_LFO,
			RST_PTR_LIM);
		build_header(MAX_INST, 1'b0);
		send_candidate();
		build_header(MAX_INST + 1, 1'b0);
		while (hdr_words.size() > 5) void'(hdr_words.pop_back());
		send_candidate();
	endtask

	// mostly good headers with random content, some broken, some noise
	task automatic test_random_traffic(input int unsigned goal_words);
		int unsigned goal, roll;
		goal = words_fed + goal_words;
		while (words_fed < goal) begin
			roll = $urandom_range(99, 0);
			if (roll < 8) begin
				hdr_words.delete();
				repeat ($urandom_range(8, 1)) hdr_words = {hdr_words, 16'($urandom)};
				hdr_bytes = 16'($urandom);
				send_candidate();
			end else if (roll < 14) begin
				repeat ($urandom_range(3, 1)) send_word(16'($urandom), 1'b0, 16'($urandom));
			end else begin
				build_header(pick_count(), $urandom_range(9, 0) == 0);
				if (roll < 40) spoil_header();
				send_candidate();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_rejects();
		test_table_walk();
		test_register_extremes();
		test_largest_table();
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct  = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			if (ph == 0)
				load_config(RST_MAX_MIX, RST_MAX_VEL, RST_SPEC_VEL, RST_MAX_ENV,
					RST_MAX_LFO, RST_PTR_LIM);
			else
				load_config(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
					8'($urandom_range(255, 0)), 8'($urandom_range(255, 1)),
					8'($urandom_range(255, 0)), 16'($urandom_range(65535, 8192)));
			test_random_traffic(PHASE_WORDS);
		end
		wait_drained();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/ibhc_pkg.sv
src/instrument_bank_header_check.sv
src/ibhc_checker.sv
verif/tb_instrument_bank_header_check.sv
